// ===== hw/rtl/wagr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average ramp generator package
// Shared widths, register indexes, request types and helper functions.
// ----------------------------------------------------------------------------
package wagr_pkg;

  localparam int MaxWindow  = 64;
  localparam int MaxRamp    = 64;
  localparam int SlotW      = 6;
  localparam int SampleW    = 32;
  localparam int ValW       = 38;
  localparam int CfgW       = 7;
  localparam int CfgIdxW    = 2;
  localparam int AddrW      = $clog2(MaxWindow);
  localparam int PtrW       = $clog2(MaxWindow + 1);
  localparam int DiffW      = ValW + 1;
  localparam int CurW       = ValW + 2;
  localparam int DivBits    = 4;
  localparam int DivIters   = (ValW + DivBits - 1) / DivBits;
  localparam int DivW       = DivIters * DivBits;
  localparam int DivCntW    = $clog2(DivIters);
  localparam int RemW       = CfgW + 1;
  localparam int ShiftW     = $clog2($clog2(MaxRamp) + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW  = 2'd0,
    REG_RAMP    = 2'd1,
    REG_AVERAGE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SlotW-1:0]   slot_index;
    logic [SampleW-1:0] sample_value;
    logic [ValW-1:0]    shown_value;
  } in_req_t;

  typedef struct packed {
    logic [ValW-1:0] ramp_value;
    logic            last_of_run;
    logic            index_error;
  } out_req_t;

  typedef struct packed {
    logic [ValW-1:0]         start;
    logic [ValW-1:0]         goal;
    logic signed [DiffW-1:0] step;
    logic [CfgW-1:0]         nramp;
    logic                    err;
  } job_t;

  function automatic logic [CfgW-1:0] eff_window(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > CfgW'(MaxWindow)) begin
      r = CfgW'(MaxWindow);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CfgW-1:0] eff_ramp(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > CfgW'(MaxRamp)) begin
      r = CfgW'(MaxRamp);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ShiftW-1:0] floor_log2(input logic [CfgW-1:0] v);
    logic [ShiftW-1:0] r;
    r = '0;
    for (int i = 0; i < CfgW; i++) begin
      if (v[i]) begin
        r = ShiftW'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/windowed_average_ramp_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average ramp generator
// Each in-range request stores a sample in a window slot; every request
// emits a ramp from the shown value towards the window sum or average.
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i/in_ready_o; each produces ramp_length results
// on out_valid_o/out_ready_i, the final one marked by last_of_run. The write
// port sets window length, ramp length and average mode and must only be
// used while the block is idle.
// The front end takes one request at a time: slot read, radix-16 division
// in average mode only, difference, hand-off. The ramp unit emits one value
// per cycle while the receiver accepts them.
// Reset clears the window through per-slot valid bits and loads the default
// registers. Writing the window length starts a summing pass over the
// window slots during which no request is taken.
// A stalled receiver holds the output register; a two-entry job queue lets
// the front end keep working until it fills.
// ----------------------------------------------------------------------------
module windowed_average_ramp_generator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  wagr_pkg::in_req_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output wagr_pkg::out_req_t           out_req_o,
  input  logic                         cfg_we_i,
  input  logic [wagr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wagr_pkg::CfgW-1:0]    cfg_data_i
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  wagr_pkg::job_t push_job, pop_job;

  wagr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o      (push_job)
  );

  wagr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_i      (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_o       (pop_job)
  );

  wagr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_i      (pop_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

endmodule

// ===== hw/rtl/wagr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wagr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/wagr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average ramp generator front end
// Takes requests, updates the sample window, forms the target and the ramp
// step, and hands a finished job to the queue.
// ----------------------------------------------------------------------------
module wagr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  wagr_pkg::in_req_t            in_req_i,
  input  logic                         cfg_we_i,
  input  logic [wagr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wagr_pkg::CfgW-1:0]    cfg_data_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output wagr_pkg::job_t               job_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SWEEP = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_DIFF  = 6'b010000,
    ST_PUSH  = 6'b100000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [wagr_pkg::CfgW-1:0]      win_q, win_d, ramp_q, ramp_d;
  logic                           avg_q, avg_d;
  logic [wagr_pkg::MaxWindow-1:0] valid_q, valid_d;
  logic [wagr_pkg::ValW-1:0]      total_q, total_d;
  logic [wagr_pkg::ValW-1:0]      sum_q, sum_d;
  logic [wagr_pkg::PtrW-1:0]      ptr_q, ptr_d;
  logic                           pend_q, pend_d;
  logic [wagr_pkg::AddrW-1:0]     pidx_q, pidx_d;

  logic [wagr_pkg::SlotW-1:0]     slot_q, slot_d;
  logic [wagr_pkg::SampleW-1:0]   sample_q, sample_d;
  logic [wagr_pkg::ValW-1:0]      shown_q, shown_d;
  logic                           err_q, err_d;
  logic [wagr_pkg::ValW-1:0]      target_q, target_d;
  logic [wagr_pkg::DivW-1:0]      quo_q, quo_d;
  logic [wagr_pkg::CfgW-1:0]      rem_q, rem_d;
  logic [wagr_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic signed [wagr_pkg::DiffW-1:0] diff_q, diff_d;

  logic [wagr_pkg::CfgW-1:0]      win_eff, ramp_eff, new_win_eff;
  logic [wagr_pkg::SampleW-1:0]   rdata, old_val;
  logic [wagr_pkg::AddrW-1:0]     ram_raddr;
  logic                           ram_we;
  logic [wagr_pkg::RemW-1:0]      div_r;
  logic [wagr_pkg::DivW-1:0]      div_q;
  logic [wagr_pkg::ShiftW-1:0]    halvings;
  logic [wagr_pkg::DiffW-1:0]     lost_mask;
  logic                           lost;
  logic signed [wagr_pkg::DiffW-1:0] step_sh, step_a, step_v;

  assign win_eff     = wagr_pkg::eff_window(win_q);
  assign ramp_eff    = wagr_pkg::eff_ramp(ramp_q);
  assign new_win_eff = wagr_pkg::eff_window(cfg_data_i);
  assign ram_raddr   = (state_q == ST_SWEEP) ? ptr_q[wagr_pkg::AddrW-1:0]
                                             : in_req_i.slot_index;
  assign old_val     = valid_q[slot_q] ? rdata : '0;
  assign in_ready_o  = (state_q == ST_IDLE);

  wagr_ram #(
    .Width(wagr_pkg::SampleW),
    .Depth(wagr_pkg::MaxWindow)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(sample_q),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // Four restoring division steps per cycle.
  always_comb begin
    div_r = {1'b0, rem_q};
    div_q = quo_q;
    for (int j = 0; j < wagr_pkg::DivBits; j++) begin
      div_r = {div_r[wagr_pkg::RemW-2:0], div_q[wagr_pkg::DivW-1]};
      div_q = {div_q[wagr_pkg::DivW-2:0], 1'b0};
      if (div_r >= wagr_pkg::RemW'(win_eff)) begin
        div_r    = div_r - wagr_pkg::RemW'(win_eff);
        div_q[0] = 1'b1;
      end
    end
  end

  // The step is the difference shifted right by floor(log2(ramp length)) bits,
  // truncated towards zero, and at least one in magnitude for nonzero input.
  always_comb begin
    halvings  = wagr_pkg::floor_log2(ramp_eff);
    step_sh   = diff_q >>> halvings;
    lost_mask = (wagr_pkg::DiffW'(1) << halvings) - wagr_pkg::DiffW'(1);
    lost      = |($unsigned(diff_q) & lost_mask);
    step_a    = step_sh + ((diff_q[wagr_pkg::DiffW-1] && lost) ? wagr_pkg::DiffW'(1)
                                                              : wagr_pkg::DiffW'(0));
    step_v    = step_a;
    if (step_a == '0 && diff_q != '0) begin
      step_v = diff_q[wagr_pkg::DiffW-1] ? '1 : wagr_pkg::DiffW'(1);
    end
  end

  always_comb begin
    job_o.start = shown_q;
    job_o.goal  = target_q;
    job_o.step  = step_v;
    job_o.nramp = ramp_eff;
    job_o.err   = err_q;
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    ramp_d      = ramp_q;
    avg_d       = avg_q;
    valid_d     = valid_q;
    total_d     = total_q;
    sum_d       = sum_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    slot_d      = slot_q;
    sample_d    = sample_q;
    shown_d     = shown_q;
    err_d       = err_q;
    target_d    = target_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    diff_d      = diff_q;
    ram_we      = 1'b0;
    job_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          slot_d   = in_req_i.slot_index;
          sample_d = in_req_i.sample_value;
          shown_d  = in_req_i.shown_value;
          err_d    = (wagr_pkg::CfgW'(in_req_i.slot_index) >= win_eff);
          state_d  = ST_READ;
        end
      end
      ST_SWEEP: begin
        if (pend_q && valid_q[pidx_q]) begin
          sum_d = sum_q + wagr_pkg::ValW'(rdata);
        end
        if (ptr_q < wagr_pkg::PtrW'(win_eff)) begin
          pend_d = 1'b1;
          pidx_d = ptr_q[wagr_pkg::AddrW-1:0];
          ptr_d  = ptr_q + wagr_pkg::PtrW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            total_d = sum_q;
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (!err_q) begin
          ram_we          = 1'b1;
          valid_d[slot_q] = 1'b1;
          total_d         = total_q - wagr_pkg::ValW'(old_val)
                            + wagr_pkg::ValW'(sample_q);
        end
        if (avg_q) begin
          quo_d   = wagr_pkg::DivW'(total_d);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          target_d = total_d;
          state_d  = ST_DIFF;
        end
      end
      ST_DIV: begin
        quo_d = div_q;
        rem_d = div_r[wagr_pkg::CfgW-1:0];
        cnt_d = cnt_q + wagr_pkg::DivCntW'(1);
        if (cnt_q == wagr_pkg::DivCntW'(wagr_pkg::DivIters - 1)) begin
          target_d = div_q[wagr_pkg::ValW-1:0];
          state_d  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_d  = $signed({1'b0, target_q}) - $signed({1'b0, shown_q});
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        wagr_pkg::REG_WINDOW: begin
          win_d = cfg_data_i;
          for (int i = 0; i < wagr_pkg::MaxWindow; i++) begin
            if (wagr_pkg::PtrW'(i) >= wagr_pkg::PtrW'(new_win_eff)) begin
              valid_d[i] = 1'b0;
            end
          end
          sum_d   = '0;
          ptr_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_SWEEP;
        end
        wagr_pkg::REG_RAMP: begin
          ramp_d = cfg_data_i;
        end
        wagr_pkg::REG_AVERAGE: begin
          avg_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= wagr_pkg::CfgW'(8);
      ramp_q  <= wagr_pkg::CfgW'(16);
      avg_q   <= 1'b1;
      valid_q <= '0;
      total_q <= '0;
      sum_q   <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      ramp_q  <= ramp_d;
      avg_q   <= avg_d;
      valid_q <= valid_d;
      total_q <= total_d;
      sum_q   <= sum_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    slot_q   <= slot_d;
    sample_q <= sample_d;
    shown_q  <= shown_d;
    err_q    <= err_d;
    target_q <= target_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    diff_q   <= diff_d;
  end

endmodule

// ===== hw/rtl/wagr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average ramp generator job queue
// Short queue of prepared jobs between the front end and the ramp unit.
// ----------------------------------------------------------------------------
module wagr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  wagr_pkg::job_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output wagr_pkg::job_t pop_o
);

  wagr_pkg::job_t                mem_q [wagr_pkg::QueueDepth];
  logic [wagr_pkg::QPtrW-1:0]    wptr_q, rptr_q;
  logic [wagr_pkg::QCntW-1:0]    cnt_q;
  logic                          push, pop;

  assign push_ready_o = (cnt_q != wagr_pkg::QCntW'(wagr_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + wagr_pkg::QPtrW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + wagr_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + wagr_pkg::QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - wagr_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_i;
    end
  end

endmodule

// ===== hw/rtl/wagr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average ramp generator ramp unit
// Steps from the shown value towards the target and drives the output
// register, one ramp value per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module wagr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  wagr_pkg::job_t     pop_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wagr_pkg::out_req_t out_req_o
);

  wagr_pkg::job_t                   job_q, job_d;
  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [wagr_pkg::CfgW-1:0]        k_q, k_d;
  logic signed [wagr_pkg::CurW-1:0] cur_q, cur_d;
  logic                             out_valid_q, out_valid_d;
  wagr_pkg::out_req_t               out_q, out_d;

  logic                             adv, emit, last, take;
  logic                             step_pos, step_neg;
  logic signed [wagr_pkg::CurW-1:0] step_x, goal_x, cur_next;
  logic [wagr_pkg::ValW-1:0]        value;
  logic                             reached;

  always_comb begin
    adv      = !out_valid_q || out_ready_i;
    emit     = busy_q && adv;
    last     = (k_q == (job_q.nramp - wagr_pkg::CfgW'(1)));
    take     = pop_valid_i && (!busy_q || (emit && last));
    step_neg = job_q.step[wagr_pkg::DiffW-1];
    step_pos = !step_neg && (job_q.step != '0);
    step_x   = {{(wagr_pkg::CurW - wagr_pkg::DiffW){job_q.step[wagr_pkg::DiffW-1]}},
                job_q.step};
    goal_x   = $signed({{(wagr_pkg::CurW - wagr_pkg::ValW){1'b0}}, job_q.goal});
    cur_next = cur_q + step_x;
    reached  = 1'b0;
    value    = job_q.goal;
    if (!done_q && (step_pos || step_neg)) begin
      if ((step_pos && cur_next < goal_x) || (step_neg && cur_next > goal_x)) begin
        value = cur_next[wagr_pkg::ValW-1:0];
      end else begin
        reached = 1'b1;
      end
    end
  end

  assign pop_ready_o = take;

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    done_d      = done_q;
    k_d         = k_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (emit) begin
      out_valid_d           = 1'b1;
      out_d.ramp_value      = value;
      out_d.last_of_run     = last;
      out_d.index_error     = job_q.err;
      k_d                   = k_q + wagr_pkg::CfgW'(1);
      cur_d                 = cur_next;
      done_d                = done_q || reached;
      if (last) begin
        busy_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (take) begin
      job_d  = pop_i;
      cur_d  = $signed({{(wagr_pkg::CurW - wagr_pkg::ValW){1'b0}}, pop_i.start});
      k_d    = '0;
      done_d = 1'b0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      k_q         <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== hw/rtl/wagr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed average ramp generator port checker
// Watches the top-level ports for handshake and run consistency.
// ----------------------------------------------------------------------------
module wagr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input wagr_pkg::out_req_t out_req_o
);

  logic mid_q, err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
      err_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      mid_q <= !out_req_o.last_of_run;
      err_q <= out_req_o.index_error;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("output request changed while stalled");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front end took a second request at once");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_run_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mid_q |-> out_req_o.index_error == err_q)
    else $error("index error flag changed within a run");

endmodule

bind windowed_average_ramp_generator_core wagr_checker u_wagr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_req_o  (out_req_o)
);
